// File: rtl/core/bpa_pkg.sv
// Shared types and constants of the buddy page allocator core.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package bpa_pkg;

   localparam int TOP_ORDER = 10;
   localparam int NUM_LISTS = TOP_ORDER + 1;
   localparam int ORD_W     = 4;
   localparam int COUNT_W   = 11;
   localparam int FRAME_W   = 21;
   localparam int BASE_W    = 20;
   localparam int REGION_W  = 16;
   localparam int CNT_W     = 16;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0]    CNT_FULL     = 16'hFFFF;
   localparam logic [BASE_W-1:0]   BASE_RESET   = 20'd524288;
   localparam logic [REGION_W-1:0] REGION_RESET = 16'd32768;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PAGE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_PAGES = 1'd1;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_COUNT = 3'd2,
      ST_RANGE = 3'd3,
      ST_ALIGN = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_CARVE,
      S_TAKE,
      S_LINK,
      S_SPLIT,
      S_FSTART,
      S_FWALK,
      S_FPUSH,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic dispatch;
      logic carve_push;
      logic take_head;
      logic load_head;
      logic split_push;
      logic walk_start;
      logic walk_step;
      logic free_push;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   go;
      logic   carve_more;
      logic   need_link;
      logic   split_more;
      logic   merge_top;
      logic   walk_found;
      logic   walk_last;
      logic   rsp_busy;
   } dp_sts_type;

endpackage

`default_nettype wire

// File: rtl/core/buddy_page_allocator_core.sv
// Top level of the buddy page allocator core.
// Depends on bpa_pkg, bpa_controller and bpa_datapath.
//
// A request carries an operation (allocate, free, initialize, no-op), a page
// count and, for free, an absolute page frame. It is taken when req_valid is
// high and req_stall is low; exactly one response follows on the rsp_ channel
// and is held until taken (rsp_valid high, rsp_stall low). One request is in
// work at a time. An allocate pops the first non-empty list, reloads its head
// from the next-link memory if entries remain, then splits off one half per
// step. A free walks one list entry per step per merge level, since each step
// reads the next-link memory through its single registered read port.
// Initialize carves one block per step. The user must write configuration
// via the csr_ port only while the core is idle; the core does not check it.
// Reset empties every free list and loads the default region registers; the
// next-link memory is not cleared, since every entry is written when its
// block is listed. Initialize must be issued before the lists hold blocks.
// A stalled response holds the core after it finishes the next request.
`default_nettype none

module buddy_page_allocator_core
   import bpa_pkg::*;
#(
   parameter int MAX_PAGES = 32768
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BASE_W-1:0]    csr_write_data,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_operation,
   input  wire logic [COUNT_W-1:0]   req_page_count,
   input  wire logic [FRAME_W-1:0]   req_page_frame,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [FRAME_W-1:0]        rsp_block_frame,
   output logic [ORD_W-1:0]          rsp_block_order
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // The controller sequences each request; the datapath owns all storage.
   bpa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpa_datapath #(
      .MAX_PAGES (MAX_PAGES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_operation),
      .req_page_count   (req_page_count),
      .req_page_frame   (req_page_frame),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_block_frame  (rsp_block_frame),
      .rsp_block_order  (rsp_block_order)
   );

endmodule

`default_nettype wire

// File: rtl/core/bpa_controller.sv
// Sequencing state machine of the buddy page allocator core.
// Depends on bpa_pkg; drives datapath commands from datapath status.
`default_nettype none

module bpa_controller
   import bpa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            case (sts.op)
               OP_INIT:  state_in = S_CARVE;
               OP_ALLOC: state_in = sts.go ? S_TAKE : S_DONE;
               OP_FREE:  state_in = sts.go ? S_FSTART : S_DONE;
               default:  state_in = S_DONE;
            endcase
         end
         S_CARVE: begin
            if (!sts.carve_more) state_in = S_DONE;
         end
         S_TAKE: begin
            state_in = sts.need_link ? S_LINK : S_SPLIT;
         end
         S_LINK: begin
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            if (!sts.split_more) state_in = S_DONE;
         end
         S_FSTART: begin
            state_in = sts.merge_top ? S_FPUSH : S_FWALK;
         end
         S_FWALK: begin
            if (sts.walk_found) state_in = S_FSTART;
            else if (sts.walk_last) state_in = S_FPUSH;
         end
         S_FPUSH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!sts.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:     cmd.capture    = req_valid && !req_stall;
         S_DISPATCH: cmd.dispatch   = 1'b1;
         S_CARVE:    cmd.carve_push = sts.carve_more;
         S_TAKE:     cmd.take_head  = 1'b1;
         S_LINK:     cmd.load_head  = 1'b1;
         S_SPLIT:    cmd.split_push = sts.split_more;
         S_FSTART:   cmd.walk_start = !sts.merge_top;
         S_FWALK:    cmd.walk_step  = 1'b1;
         S_FPUSH:    cmd.free_push  = 1'b1;
         S_DONE:     cmd.finish     = !sts.rsp_busy;
         default:    cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/bpa_datapath.sv
// Datapath of the buddy page allocator core: free-list heads and counts,
// next-link memory, request and result registers. Depends on bpa_pkg.
`default_nettype none

module bpa_datapath
   import bpa_pkg::*;
#(
   parameter int MAX_PAGES = 32768
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BASE_W-1:0]    csr_write_data,
   input  wire logic [1:0]           req_operation,
   input  wire logic [COUNT_W-1:0]   req_page_count,
   input  wire logic [FRAME_W-1:0]   req_page_frame,
   input  wire logic                 rsp_stall,
   input  wire dp_cmd_type           cmd,
   output dp_sts_type                sts,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [FRAME_W-1:0]        rsp_block_frame,
   output logic [ORD_W-1:0]          rsp_block_order
);

   localparam int IDX_W = $clog2(MAX_PAGES);
   localparam logic [FRAME_W-1:0] MAX_W = FRAME_W'(MAX_PAGES);

   // Configuration.
   logic [BASE_W-1:0]   base_ff;
   logic [REGION_W-1:0] region_ff;

   // Latched request.
   op_type             op_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [ORD_W-1:0]   ord_ff;
   logic               bad_ff;

   // Free lists.
   logic [IDX_W-1:0] head_ff [NUM_LISTS];
   logic [CNT_W-1:0] cnt_ff  [NUM_LISTS];

   // Working registers.
   logic [ORD_W-1:0]   k_ff;
   logic [FRAME_W-1:0] pos_ff;
   logic [IDX_W-1:0]   cur_ff, prev_ff;
   logic [CNT_W-1:0]   walk_idx_ff;
   status_type         res_ff;

   // Next-link memory.
   logic [IDX_W-1:0] link_mem [MAX_PAGES];
   logic [IDX_W-1:0] rdata_ff;

   // Result register.
   logic               rsp_valid_ff;
   status_type         status_ff;
   logic [FRAME_W-1:0] bframe_ff;
   logic [ORD_W-1:0]   border_ff;

   logic [ORD_W-1:0]   ord_c, found_k, carve_o, lsel;
   logic               bad_c, found_any;
   logic [FRAME_W-1:0] size, rel_c, blksz, mate, push_blk;
   logic               range_err, align_err, push_en, push_ok;
   logic               mem_we, mem_re;
   logic [IDX_W-1:0]   waddr, wdata, raddr;

   assign size = (FRAME_W'(region_ff) > MAX_W) ? MAX_W : FRAME_W'(region_ff);

   // Order from page count: smallest k with 2^k >= count.
   always_comb begin
      ord_c = '0;
      for (int k = TOP_ORDER; k >= 0; k--) begin
         if ((32'(1) << k) >= 32'(req_page_count)) ord_c = ORD_W'(k);
      end
      bad_c = (req_page_count == '0) || (32'(req_page_count) > (32'(1) << TOP_ORDER));
   end

   // First non-empty list at or above the requested order.
   always_comb begin
      found_k   = '0;
      found_any = 1'b0;
      for (int k = TOP_ORDER; k >= 0; k--) begin
         if ((ORD_W'(k) >= ord_ff) && (cnt_ff[k] != '0)) begin
            found_k   = ORD_W'(k);
            found_any = 1'b1;
         end
      end
   end

   // Free checks, relative to the region base.
   assign rel_c     = frame_ff - FRAME_W'(base_ff);
   assign blksz     = FRAME_W'(1) << ord_ff;
   assign range_err = (frame_ff < FRAME_W'(base_ff)) || (rel_c >= size)
                      || (blksz > size - rel_c);
   assign align_err = (rel_c & (blksz - FRAME_W'(1))) != '0;

   // Largest aligned block that still fits at the carve position.
   always_comb begin
      carve_o = '0;
      for (int o = 0; o < NUM_LISTS; o++) begin
         if ((pos_ff + (FRAME_W'(1) << o) <= size)
             && ((pos_ff & ((FRAME_W'(1) << o) - FRAME_W'(1))) == '0)) begin
            carve_o = ORD_W'(o);
         end
      end
   end

   assign mate = pos_ff ^ (FRAME_W'(1) << k_ff);

   // One list is addressed per cycle.
   always_comb begin
      if (cmd.carve_push) lsel = carve_o;
      else if (cmd.split_push) lsel = k_ff - ORD_W'(1);
      else lsel = k_ff;
   end

   always_comb begin
      push_en  = cmd.carve_push || cmd.split_push || cmd.free_push;
      push_blk = pos_ff;
      if (cmd.split_push) push_blk = pos_ff + (FRAME_W'(1) << (k_ff - ORD_W'(1)));
      push_ok  = (cnt_ff[lsel] != CNT_FULL) && (push_blk < MAX_W);
   end

   // Memory port control.
   always_comb begin
      mem_we = 1'b0;
      waddr  = push_blk[IDX_W-1:0];
      wdata  = (cnt_ff[lsel] != '0) ? head_ff[lsel] : '0;
      if (push_en && push_ok) begin
         mem_we = 1'b1;
      end else if (cmd.walk_step && (FRAME_W'(cur_ff) == mate) && (walk_idx_ff != '0)) begin
         mem_we = 1'b1;
         waddr  = prev_ff;
         wdata  = rdata_ff;
      end
      mem_re = cmd.take_head || cmd.walk_start || cmd.walk_step;
      raddr  = cmd.walk_step ? rdata_ff : head_ff[lsel];
   end

   always_ff @(posedge clock) begin
      if (mem_we) link_mem[waddr] <= wdata;
      if (mem_re) rdata_ff <= link_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         region_ff <= REGION_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE_PAGE:    base_ff   <= csr_write_data;
            CSR_REGION_PAGES: region_ff <= csr_write_data[REGION_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_operation);
         frame_ff <= req_page_frame;
         ord_ff   <= ord_c;
         bad_ff   <= bad_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LISTS; k++) begin
            head_ff[k] <= '0;
            cnt_ff[k]  <= '0;
         end
         k_ff        <= '0;
         pos_ff      <= '0;
         cur_ff      <= '0;
         prev_ff     <= '0;
         walk_idx_ff <= '0;
         res_ff      <= ST_OK;
      end else begin
         if (cmd.dispatch) begin
            case (op_ff)
               OP_INIT: begin
                  res_ff <= ST_OK;
                  for (int k = 0; k < NUM_LISTS; k++) begin
                     head_ff[k] <= '0;
                     cnt_ff[k]  <= '0;
                  end
                  pos_ff <= '0;
               end
               OP_ALLOC: begin
                  if (bad_ff) res_ff <= ST_COUNT;
                  else if (!found_any) res_ff <= ST_EMPTY;
                  else res_ff <= ST_OK;
                  k_ff <= found_k;
               end
               OP_FREE: begin
                  if (bad_ff) res_ff <= ST_COUNT;
                  else if (range_err) res_ff <= ST_RANGE;
                  else if (align_err) res_ff <= ST_ALIGN;
                  else res_ff <= ST_OK;
                  k_ff   <= ord_ff;
                  pos_ff <= rel_c;
               end
               default: res_ff <= ST_OK;
            endcase
         end
         if (push_en && push_ok) begin
            head_ff[lsel] <= push_blk[IDX_W-1:0];
            cnt_ff[lsel]  <= cnt_ff[lsel] + CNT_W'(1);
         end
         if (cmd.carve_push) pos_ff <= pos_ff + (FRAME_W'(1) << carve_o);
         if (cmd.split_push) k_ff <= k_ff - ORD_W'(1);
         if (cmd.take_head) begin
            pos_ff       <= FRAME_W'(head_ff[lsel]);
            cnt_ff[lsel] <= cnt_ff[lsel] - CNT_W'(1);
         end
         if (cmd.load_head) head_ff[lsel] <= rdata_ff;
         if (cmd.walk_start) begin
            cur_ff      <= head_ff[lsel];
            walk_idx_ff <= '0;
         end
         if (cmd.walk_step) begin
            if (FRAME_W'(cur_ff) == mate) begin
               if (walk_idx_ff == '0) head_ff[lsel] <= rdata_ff;
               cnt_ff[lsel] <= cnt_ff[lsel] - CNT_W'(1);
               if (mate < pos_ff) pos_ff <= mate;
               k_ff <= k_ff + ORD_W'(1);
            end else begin
               walk_idx_ff <= walk_idx_ff + CNT_W'(1);
               prev_ff     <= cur_ff;
               cur_ff      <= rdata_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff <= res_ff;
         if (res_ff == ST_OK && op_ff == OP_ALLOC) begin
            bframe_ff <= FRAME_W'(base_ff) + pos_ff;
            border_ff <= ord_ff;
         end else if (res_ff == ST_OK && op_ff == OP_FREE) begin
            bframe_ff <= '0;
            border_ff <= k_ff;
         end else begin
            bframe_ff <= '0;
            border_ff <= '0;
         end
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.go         = (op_ff == OP_ALLOC) ? (!bad_ff && found_any)
                                           : (!bad_ff && !range_err && !align_err);
      sts.carve_more = pos_ff < size;
      sts.need_link  = cnt_ff[lsel] > CNT_W'(1);
      sts.split_more = k_ff > ord_ff;
      sts.merge_top  = (k_ff == ORD_W'(TOP_ORDER)) || (cnt_ff[lsel] == '0);
      sts.walk_found = FRAME_W'(cur_ff) == mate;
      sts.walk_last  = (walk_idx_ff + CNT_W'(1)) == cnt_ff[lsel];
      sts.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_block_frame = bframe_ff;
   assign rsp_block_order = border_ff;

`ifndef SYNTHESIS
   a_walk_in_list: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> walk_idx_ff < cnt_ff[lsel])
      else $error("free-list walk ran past the list length");
   a_link_after_take: assert property (@(posedge clock) disable iff (reset)
      cmd.load_head |-> $past(cmd.take_head))
      else $error("head reload without a preceding pop");
   a_order_bound: assert property (@(posedge clock) disable iff (reset)
      push_en |-> lsel <= ORD_W'(TOP_ORDER))
      else $error("push to a list beyond the top order");
`endif

endmodule

`default_nettype wire

// File: test/buddy_page_allocator_core_test.sv
// Self-checking testbench for the buddy page allocator core.
// Depends on bpa_pkg and buddy_page_allocator_core, and through it on bpa_controller and bpa_datapath.
// Requests and responses are checked against an allocator model kept here.
`default_nettype none

module buddy_page_allocator_core_test;
   import bpa_pkg::*;

   localparam int MAX_PAGES  = 32768;
   localparam int IDLE_LIMIT = 200000;
   localparam logic [FRAME_W-1:0] FRAME_MASK = '1;

   // One response as the core should present it.
   typedef struct {
      status_type         status;
      logic [FRAME_W-1:0] frame;
      logic [ORD_W-1:0]   order;
   } reply_type;

   // A block that the model has handed out and that may be freed later.
   typedef struct {
      logic [FRAME_W-1:0] frame;
      int                 order;
   } held_block_type;

   // One row of the directed table. When fixed is set, the response is the
   // typed-in one; otherwise the allocator model decides it.
   typedef struct {
      op_type             op;
      logic [COUNT_W-1:0] count;
      logic [FRAME_W-1:0] frame;
      bit                 fixed;
      status_type         status;
      logic [FRAME_W-1:0] bframe;
      logic [ORD_W-1:0]   border;
   } directed_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BASE_W-1:0]    csr_write_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_operation;
   logic [COUNT_W-1:0]   req_page_count;
   logic [FRAME_W-1:0]   req_page_frame;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [STATUS_W-1:0]  rsp_status;
   logic [FRAME_W-1:0]   rsp_block_frame;
   logic [ORD_W-1:0]     rsp_block_order;

   buddy_page_allocator_core #(.MAX_PAGES(MAX_PAGES)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_page_count   (req_page_count),
      .req_page_frame   (req_page_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_block_frame  (rsp_block_frame),
      .rsp_block_order  (rsp_block_order)
   );

   // Model state: a LIFO free list per order, held as head, per-page next
   // link and length, plus a copy of the two region registers.
   logic [31:0] model_base;
   logic [31:0] model_region;
   logic [31:0] list_top  [NUM_LISTS];
   logic [31:0] list_len  [NUM_LISTS];
   logic [31:0] page_link [MAX_PAGES];

   reply_type      pending_replies[$];
   held_block_type held_blocks[$];
   int             errors;
   int             send_idle_pct;
   int             stall_pct;
   int             quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] next_of(logic [31:0] idx);
      return (idx < MAX_PAGES) ? page_link[idx] : 32'd0;
   endfunction

   function automatic logic [31:0] usable_pages();
      return (model_region > MAX_PAGES) ? MAX_PAGES : model_region;
   endfunction

   // A push onto a full list, or of a block beyond the memory, is dropped.
   function automatic void list_push(int k, logic [31:0] blk);
      if (list_len[k] >= CNT_FULL || blk >= MAX_PAGES)
         return;
      page_link[blk] = (list_len[k] != 0) ? list_top[k] : 32'd0;
      list_top[k] = blk;
      list_len[k] = list_len[k] + 1;
   endfunction

   // Unlinks the target block from list k if it is there.
   function automatic bit list_unlink(int k, logic [31:0] target);
      logic [31:0] cur;
      logic [31:0] prev;
      cur = list_top[k];
      prev = 0;
      for (int i = 0; i < list_len[k]; i++) begin
         if (cur == target) begin
            if (i == 0)
               list_top[k] = next_of(cur);
            else if (prev < MAX_PAGES)
               page_link[prev] = next_of(cur);
            list_len[k] = list_len[k] - 1;
            return 1'b1;
         end
         prev = cur;
         cur = next_of(cur);
      end
      return 1'b0;
   endfunction

   // Smallest order whose block holds count pages, or -1 for a bad count.
   function automatic int order_of_count(logic [COUNT_W-1:0] count);
      int k;
      k = 0;
      if (count == 0 || count > (1 << TOP_ORDER))
         return -1;
      while ((1 << k) < count)
         k++;
      return k;
   endfunction

   // Computes the response to one request and updates the free lists.
   function automatic reply_type allocator_step(op_type op, logic [COUNT_W-1:0] count,
                                                logic [FRAME_W-1:0] frame);
      reply_type   r;
      int          o;
      int          k;
      logic [31:0] rel;
      logic [31:0] size;
      logic [31:0] lim;
      logic [31:0] blk;
      logic [31:0] mate;
      r.status = ST_OK;
      r.frame = '0;
      r.order = '0;
      case (op)
         OP_INIT: begin
            for (int i = 0; i < NUM_LISTS; i++) begin
               list_top[i] = 0;
               list_len[i] = 0;
            end
            lim = usable_pages();
            rel = 0;
            // Largest block that fits and is aligned to the region start.
            while (rel < lim) begin
               k = TOP_ORDER;
               while (k > 0 && (rel + (1 << k) > lim || (rel & ((1 << k) - 1)) != 0))
                  k--;
               list_push(k, rel);
               rel = rel + (1 << k);
            end
         end
         OP_ALLOC: begin
            o = order_of_count(count);
            if (o < 0) begin
               r.status = ST_COUNT;
            end else begin
               k = o;
               while (k <= TOP_ORDER && list_len[k] == 0)
                  k++;
               if (k > TOP_ORDER) begin
                  r.status = ST_EMPTY;
               end else begin
                  blk = list_top[k];
                  if (list_len[k] > 1)
                     list_top[k] = next_of(blk);
                  list_len[k] = list_len[k] - 1;
                  // The upper halves split off on the way down are listed.
                  while (k > o) begin
                     k--;
                     list_push(k, blk + (1 << k));
                  end
                  r.frame = FRAME_W'(model_base + blk) & FRAME_MASK;
                  r.order = ORD_W'(o);
               end
            end
         end
         OP_FREE: begin
            o = order_of_count(count);
            if (o < 0) begin
               r.status = ST_COUNT;
            end else begin
               size = 1 << o;
               lim = usable_pages();
               rel = {11'd0, frame} - model_base;
               if ({11'd0, frame} < model_base || rel >= lim || size > lim - rel) begin
                  r.status = ST_RANGE;
               end else if ((rel & (size - 1)) != 0) begin
                  r.status = ST_ALIGN;
               end else begin
                  // Merge upward while the buddy sits on the current list.
                  k = o;
                  while (k < TOP_ORDER) begin
                     mate = rel ^ (1 << k);
                     if (!list_unlink(k, mate))
                        break;
                     if (mate < rel)
                        rel = mate;
                     k++;
                  end
                  list_push(k, rel);
                  r.order = ORD_W'(k);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Acceptance on either channel restarts the idle count. A run that sits
   // without any handshake for too long has hung.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // The receiver stalls at random; the value changes only at falling edges.
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Each response taken is checked against the oldest expected one.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("response with no request waiting: status %0d", rsp_status);
            errors++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_block_frame !== want.frame) begin
               $error("block_frame: expected %0d, got %0d", want.frame, rsp_block_frame);
               errors++;
            end
            if (rsp_block_order !== want.order) begin
               $error("block_order: expected %0d, got %0d", want.order, rsp_block_order);
               errors++;
            end
         end
      end
   end

   // Drives one request, starting and ending at a falling edge. The valid is
   // left high on return, so back-to-back requests keep it up; the next call
   // either replaces the payload or lowers it, never both in one step.
   // When use_typed is set the typed-in reply is queued instead of the model's,
   // but the model still steps so its lists track the core.
   task automatic send_request(op_type op, logic [COUNT_W-1:0] count,
                               logic [FRAME_W-1:0] frame, bit use_typed,
                               reply_type typed);
      reply_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_page_count <= count;
      req_page_frame <= frame;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      r = allocator_step(op, count, frame);
      if (op == OP_INIT)
         held_blocks.delete();
      if (op == OP_ALLOC && r.status == ST_OK)
         held_blocks.push_back('{r.frame, int'(r.order)});
      pending_replies.push_back(use_typed ? typed : r);
      @(negedge clock);
   endtask

   // Lowers the valid and waits until every response has come back, then
   // lets the core settle before anything else happens.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [BASE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == CSR_BASE_PAGE)
         model_base = value;
      else
         model_region = value[REGION_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One random request. Most are well-formed: allocations of mostly small
   // sizes, and frees of blocks actually handed out, with a page count that
   // rounds to the block's order. The rest is noise: wild frames and counts,
   // occasional double frees, no-ops and re-initializations.
   task automatic random_request();
      int                 pick;
      int                 idx;
      int                 o;
      held_block_type     hb;
      logic [COUNT_W-1:0] count;
      logic [FRAME_W-1:0] frame;
      reply_type          none;
      none = '{ST_OK, '0, '0};
      pick = $urandom_range(99);
      if (pick < 45) begin
         count = ($urandom_range(99) < 80) ? COUNT_W'($urandom_range(1, 16))
                                           : COUNT_W'($urandom_range(1, 1024));
         send_request(OP_ALLOC, count, FRAME_W'($urandom), 1'b0, none);
      end else if (pick < 83 && held_blocks.size() != 0) begin
         idx = $urandom_range(held_blocks.size() - 1);
         hb = held_blocks[idx];
         // Now and then a block is freed twice, which the core does not catch.
         if (pick != 82)
            held_blocks.delete(idx);
         o = hb.order;
         count = (o == 0) ? COUNT_W'(1)
                          : COUNT_W'($urandom_range((1 << (o - 1)) + 1, 1 << o));
         send_request(OP_FREE, count, hb.frame, 1'b0, none);
      end else if (pick < 90) begin
         frame = ($urandom_range(1)) ? FRAME_W'($urandom) :
                 FRAME_W'(model_base + $urandom_range(0, usable_pages()));
         count = ($urandom_range(1)) ? COUNT_W'($urandom_range(0, 2047))
                                     : COUNT_W'(1 << $urandom_range(0, 10));
         send_request(OP_FREE, count, frame, 1'b0, none);
      end else if (pick < 95) begin
         send_request(OP_ALLOC, COUNT_W'($urandom_range(0, 2047)), FRAME_W'($urandom),
                      1'b0, none);
      end else if (pick < 97) begin
         send_request(OP_NOP, COUNT_W'($urandom), FRAME_W'($urandom), 1'b0, none);
      end else begin
         send_request(OP_INIT, COUNT_W'($urandom), FRAME_W'($urandom), 1'b0, none);
      end
   endtask

   directed_row_type directed_rows[] = '{
      // Nothing is listed after reset, so an allocation finds no block.
      '{OP_ALLOC,    11'd1,    21'd0,       1'b1, ST_EMPTY, 21'd0, 4'd0},
      '{OP_ALLOC,    11'd0,    21'd0,       1'b1, ST_COUNT, 21'd0, 4'd0},
      '{OP_ALLOC,    11'd1025, 21'd0,       1'b1, ST_COUNT, 21'd0, 4'd0},
      '{OP_FREE,     11'd0,    21'd524288,  1'b1, ST_COUNT, 21'd0, 4'd0},
      '{OP_FREE,     11'd2047, 21'd524288,  1'b1, ST_COUNT, 21'd0, 4'd0},
      '{OP_NOP,      11'd2047, 21'h1FFFFF,  1'b1, ST_OK,    21'd0, 4'd0},
      '{OP_INIT,     11'd0,    21'd0,       1'b1, ST_OK,    21'd0, 4'd0},
      '{OP_ALLOC,    11'd1024, 21'd0,       1'b0, ST_OK,    21'd0, 4'd0},
      '{OP_ALLOC,    11'd1,    21'd0,       1'b0, ST_OK,    21'd0, 4'd0},
      '{OP_ALLOC,    11'd3,    21'd0,       1'b0, ST_OK,    21'd0, 4'd0},
      // Frames outside the region, and a block running past its end.
      '{OP_FREE,     11'd1,    21'd0,       1'b1, ST_RANGE, 21'd0, 4'd0},
      '{OP_FREE,     11'd1,    21'd524287,  1'b1, ST_RANGE, 21'd0, 4'd0},
      '{OP_FREE,     11'd1,    21'd557056,  1'b1, ST_RANGE, 21'd0, 4'd0},
      '{OP_FREE,     11'd1024, 21'd556544,  1'b1, ST_RANGE, 21'd0, 4'd0},
      '{OP_FREE,     11'd1,    21'h1FFFFF,  1'b1, ST_RANGE, 21'd0, 4'd0},
      // Inside the region but not aligned to the block size.
      '{OP_FREE,     11'd2,    21'd524289,  1'b1, ST_ALIGN, 21'd0, 4'd0},
      '{OP_FREE,     11'd1024, 21'd524800,  1'b1, ST_ALIGN, 21'd0, 4'd0},
      '{OP_FREE,     11'd1,    21'd557055,  1'b0, ST_OK,    21'd0, 4'd0},
      '{OP_ALLOC,    11'd1024, 21'd0,       1'b0, ST_OK,    21'd0, 4'd0},
      '{OP_FREE,     11'd1024, 21'd524288,  1'b0, ST_OK,    21'd0, 4'd0},
      '{OP_ALLOC,    11'd2,    21'd0,       1'b0, ST_OK,    21'd0, 4'd0},
      '{OP_INIT,     11'd0,    21'd0,       1'b0, ST_OK,    21'd0, 4'd0}
   };

   // Random phases: region settings (the first keeps the reset values) and
   // how much each side idles. A zero-page region makes every allocation
   // fail, and a region above the memory size gets clipped.
   int          phase_items[6]  = '{260, 240, 240, 40, 260, 240};
   logic [19:0] phase_base[6]   = '{20'd524288, 20'd0, 20'hFFFFF, 20'd12345, 20'd4096,
                                    20'd300000};
   logic [15:0] phase_region[6] = '{16'd32768, 16'd1000, 16'd32768, 16'd0, 16'hFFFF,
                                    16'd777};
   int          phase_idle[6]   = '{0, 55, 0, 36, 0, 55};
   int          phase_stall[6]  = '{0, 0, 55, 36, 0, 55};

   initial begin
      reply_type typed;
      errors           = 0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      quiet_cycles     = 0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_BASE_PAGE;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_operation    = OP_NOP;
      req_page_count   = '0;
      req_page_frame   = '0;
      model_base       = BASE_RESET;
      model_region     = REGION_RESET;
      for (int i = 0; i < NUM_LISTS; i++) begin
         list_top[i] = 0;
         list_len[i] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table under the reset region, with no idling.
      foreach (directed_rows[i]) begin
         typed = '{directed_rows[i].status, directed_rows[i].bframe, directed_rows[i].border};
         send_request(directed_rows[i].op, directed_rows[i].count, directed_rows[i].frame,
                      directed_rows[i].fixed, typed);
      end
      drain();

      for (int p = 0; p < 6; p++) begin
         if (p != 0) begin
            csr_write(CSR_BASE_PAGE, phase_base[p]);
            csr_write(CSR_REGION_PAGES, {4'd0, phase_region[p]});
         end
         send_idle_pct = phase_idle[p];
         stall_pct     = phase_stall[p];
         held_blocks.delete();
         typed = '{ST_OK, '0, '0};
         send_request(OP_INIT, '0, '0, 1'b0, typed);
         for (int n = 0; n < phase_items[p]; n++) begin
            // Midway through one phase the sender holds off until the core
            // has answered everything, so the core sees an empty pipe.
            if (p == 2 && n == phase_items[p] / 2)
               drain();
            random_request();
         end
         drain();
      end

      stall_pct = 0;
      repeat (40) @(negedge clock);
      if (errors == 0 && pending_replies.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
